// ===== hw/rtl/v2rn_pkg.sv =====
`timescale 1ns / 1ps

package v2rn_pkg;

    // default number of cordic micro-rotations
    localparam int ROTATION_STAGES_DEF = 16;
    // fraction bits of the vector format
    localparam int FRACTION_BITS = 16;
    // extra fraction bits carried inside the cordic datapaths
    localparam int GUARD_BITS = 16;
    // cordic datapath width: 33-bit operand, guard bits, gain headroom
    localparam int CW = 51;
    // magnitude width fed to gain removal
    localparam int MAG_W = 50;
    // width of a gain-corrected magnitude
    localparam int DSC_W = MAG_W - GUARD_BITS;
    // unsaturated length width
    localparam int LEN_W = 33;
    // angle residue width in rotation mode
    localparam int RW = 34;

    localparam logic [31:0] INV_GAIN = 32'd2608131496;
    localparam logic [30:0] LEN_MAX = 31'h7FFF_FFFF;
    localparam logic [30:0] NORM_NUM = 31'd1 << FRACTION_BITS;

    localparam logic [2:0] ACT_ROTATE    = 3'd0;
    localparam logic [2:0] ACT_ROT_P90   = 3'd1;
    localparam logic [2:0] ACT_ROT_M90   = 3'd2;
    localparam logic [2:0] ACT_POLAR     = 3'd3;
    localparam logic [2:0] ACT_SET_ORI   = 3'd4;
    localparam logic [2:0] ACT_NORMALIZE = 3'd5;
    localparam logic [2:0] ACT_CLAMP     = 3'd6;
    localparam logic [2:0] ACT_SET_LEN   = 3'd7;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURNS [0:31] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [15:0]        angle;
        logic [30:0]        len_arg;
        logic [LEN_W-1:0]   len;
        logic [30:0]        len_sat;
        logic [15:0]        ori;
        logic signed [31:0] res_x;
        logic signed [31:0] res_y;
    } item_t;

    // apply sign to a magnitude and saturate to 32-bit signed
    function automatic logic [31:0] sat_apply(input logic neg, input logic [DSC_W-1:0] mag);
        logic [31:0] r;
        if (neg)
        begin
            if (mag > DSC_W'(34'h0_8000_0000))
                r = 32'h8000_0000;
            else
                r = ~mag[31:0] + 32'd1;
        end
        else
        begin
            if (mag > DSC_W'(34'h0_7FFF_FFFF))
                r = 32'h7FFF_FFFF;
            else
                r = mag[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/v2rn_descale.sv =====
`timescale 1ns / 1ps

module v2rn_descale (
    input  logic                        clk,
    input  logic                        en,
    input  logic [v2rn_pkg::MAG_W-1:0]  mag,
    output logic [v2rn_pkg::DSC_W-1:0]  res
);
    import v2rn_pkg::*;

    logic [MAG_W-1:0] hi_prod_reg;
    logic [31:0]      lo_prod_reg;
    logic [DSC_W-1:0] res_reg;
    logic [63:0]      lo_prod;
    logic [MAG_W-1:0] sum;

    // split multiply: high part exact, low part keeps its upper word
    assign lo_prod = {32'b0, mag[31:0]} * {32'b0, INV_GAIN};
    assign sum = hi_prod_reg + {{(MAG_W-32){1'b0}}, lo_prod_reg}
                 + MAG_W'(1 << (GUARD_BITS - 1));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hi_prod_reg <= {{32{1'b0}}, mag[MAG_W-1:32]} * {{(MAG_W-32){1'b0}}, INV_GAIN};
            lo_prod_reg <= lo_prod[63:32];
            res_reg     <= sum[MAG_W-1:GUARD_BITS];
        end
    end

    assign res = res_reg;

endmodule

// ===== hw/rtl/v2rn_vector.sv =====
`timescale 1ns / 1ps

module v2rn_vector #(
    parameter int STAGES = v2rn_pkg::ROTATION_STAGES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  v2rn_pkg::item_t in_item,
    output logic            out_valid,
    output v2rn_pkg::item_t out_item
);
    import v2rn_pkg::*;

    localparam int LAT = STAGES + 3;

    logic [LAT-1:0]       valid_reg;
    item_t                item_reg [0:LAT-1];
    logic signed [CW-1:0] vx_reg [0:STAGES];
    logic signed [CW-1:0] vy_reg [0:STAGES];
    logic [31:0]          vz_reg [0:STAGES];
    logic [15:0]          ori_reg;
    logic [15:0]          ori2_reg;
    logic [DSC_W-1:0]     dsc_len;
    logic signed [32:0]   px;
    logic signed [32:0]   py;
    logic                 neg_x;
    logic [31:0]          z_round;

    // half turn when x is negative
    always_comb
    begin
        neg_x = in_item.x[31];
        px = neg_x ? -{in_item.x[31], in_item.x} : {in_item.x[31], in_item.x};
        py = neg_x ? -{in_item.y[31], in_item.y} : {in_item.y[31], in_item.y};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[LAT-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg[0] <= in_item;
            vx_reg[0]   <= {{(CW-33-GUARD_BITS){px[32]}}, px, {GUARD_BITS{1'b0}}};
            vy_reg[0]   <= {{(CW-33-GUARD_BITS){py[32]}}, py, {GUARD_BITS{1'b0}}};
            vz_reg[0]   <= neg_x ? 32'h8000_0000 : 32'h0;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!vy_reg[i][CW-1])
                begin
                    vx_reg[i+1] <= vx_reg[i] + (vy_reg[i] >>> i);
                    vy_reg[i+1] <= vy_reg[i] - (vx_reg[i] >>> i);
                    vz_reg[i+1] <= vz_reg[i] + ATAN_TURNS[i];
                end
                else
                begin
                    vx_reg[i+1] <= vx_reg[i] - (vy_reg[i] >>> i);
                    vy_reg[i+1] <= vy_reg[i] + (vx_reg[i] >>> i);
                    vz_reg[i+1] <= vz_reg[i] - ATAN_TURNS[i];
                end
            end
        end
    end

    for (genvar k = 1; k < LAT; k++)
    begin : g_item
        always_ff @(posedge clk)
        begin
            if (en)
                item_reg[k] <= item_reg[k-1];
        end
    end

    // orientation rounded to 16 bits, zero vector reads as zero
    assign z_round = vz_reg[STAGES] + 32'h0000_8000;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (item_reg[STAGES].x == 32'sd0 && item_reg[STAGES].y == 32'sd0)
                ori_reg <= 16'h0;
            else
                ori_reg <= z_round[31:16];
            ori2_reg <= ori_reg;
        end
    end

    v2rn_descale u_descale (
        .clk (clk),
        .en  (en),
        .mag (vx_reg[STAGES][MAG_W-1:0]),
        .res (dsc_len)
    );

    always_comb
    begin
        out_item = item_reg[LAT-1];
        out_item.len = dsc_len[LEN_W-1:0];
        out_item.len_sat = (dsc_len > {{(DSC_W-31){1'b0}}, LEN_MAX}) ? LEN_MAX : dsc_len[30:0];
        out_item.ori = ori2_reg;
    end

    assign out_valid = valid_reg[LAT-1];

endmodule

// ===== hw/rtl/v2rn_rotate.sv =====
`timescale 1ns / 1ps

module v2rn_rotate #(
    parameter int STAGES = v2rn_pkg::ROTATION_STAGES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  v2rn_pkg::item_t in_item,
    output logic            out_valid,
    output v2rn_pkg::item_t out_item
);
    import v2rn_pkg::*;

    localparam int LAT = STAGES + 5;
    localparam int SAT_IDX = STAGES + 4;

    logic [LAT-1:0]       valid_reg;
    item_t                item_reg [0:LAT-1];
    logic signed [CW-1:0] rx_reg [0:STAGES];
    logic signed [CW-1:0] ry_reg [0:STAGES];
    logic signed [RW-1:0] rz_reg [0:STAGES];
    logic [MAG_W-1:0]     ax_reg;
    logic [MAG_W-1:0]     ay_reg;
    logic [2:0]           nx_reg;
    logic [2:0]           ny_reg;
    logic [DSC_W-1:0]     dx_mag;
    logic [DSC_W-1:0]     dy_mag;
    logic signed [CW-1:0] fx_neg;
    logic signed [CW-1:0] fy_neg;
    logic signed [32:0]   sx;
    logic signed [32:0]   sy;
    logic signed [32:0]   fx;
    logic signed [32:0]   fy;
    logic [31:0]          z0;
    logic [31:0]          zq;
    logic [31:0]          zr;
    logic                 flip;
    item_t                sat_item;

    // source vector and half-turn fold into [-1/4, 1/4) turn
    always_comb
    begin
        unique case (in_item.action)
            ACT_POLAR:
            begin
                sx = {2'b0, in_item.len_arg};
                sy = '0;
            end
            ACT_SET_ORI:
            begin
                sx = {2'b0, in_item.len_sat};
                sy = '0;
            end
            default:
            begin
                sx = {in_item.x[31], in_item.x};
                sy = {in_item.y[31], in_item.y};
            end
        endcase
        z0 = {in_item.angle, 16'h0};
        zq = z0 + 32'h4000_0000;
        flip = zq[31];
        fx = flip ? -sx : sx;
        fy = flip ? -sy : sy;
        zr = flip ? z0 + 32'h8000_0000 : z0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[LAT-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg[0] <= in_item;
            rx_reg[0]   <= {{(CW-33-GUARD_BITS){fx[32]}}, fx, {GUARD_BITS{1'b0}}};
            ry_reg[0]   <= {{(CW-33-GUARD_BITS){fy[32]}}, fy, {GUARD_BITS{1'b0}}};
            rz_reg[0]   <= {{(RW-32){zr[31]}}, zr};
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!rz_reg[i][RW-1])
                begin
                    rx_reg[i+1] <= rx_reg[i] - (ry_reg[i] >>> i);
                    ry_reg[i+1] <= ry_reg[i] + (rx_reg[i] >>> i);
                    rz_reg[i+1] <= rz_reg[i] - {{(RW-32){1'b0}}, ATAN_TURNS[i]};
                end
                else
                begin
                    rx_reg[i+1] <= rx_reg[i] + (ry_reg[i] >>> i);
                    ry_reg[i+1] <= ry_reg[i] - (rx_reg[i] >>> i);
                    rz_reg[i+1] <= rz_reg[i] + {{(RW-32){1'b0}}, ATAN_TURNS[i]};
                end
            end
        end
    end

    // magnitudes for gain removal, signs ride alongside
    assign fx_neg = -rx_reg[STAGES];
    assign fy_neg = -ry_reg[STAGES];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg <= rx_reg[STAGES][CW-1] ? fx_neg[MAG_W-1:0] : rx_reg[STAGES][MAG_W-1:0];
            ay_reg <= ry_reg[STAGES][CW-1] ? fy_neg[MAG_W-1:0] : ry_reg[STAGES][MAG_W-1:0];
            nx_reg <= {nx_reg[1:0], rx_reg[STAGES][CW-1]};
            ny_reg <= {ny_reg[1:0], ry_reg[STAGES][CW-1]};
        end
    end

    v2rn_descale u_descale_x (
        .clk (clk),
        .en  (en),
        .mag (ax_reg),
        .res (dx_mag)
    );

    v2rn_descale u_descale_y (
        .clk (clk),
        .en  (en),
        .mag (ay_reg),
        .res (dy_mag)
    );

    // signed, saturated rotation result joins the item
    always_comb
    begin
        sat_item = item_reg[SAT_IDX-1];
        sat_item.res_x = sat_apply(nx_reg[2], dx_mag);
        sat_item.res_y = sat_apply(ny_reg[2], dy_mag);
    end

    for (genvar k = 1; k < LAT; k++)
    begin : g_item
        if (k != SAT_IDX)
        begin : g_copy
            always_ff @(posedge clk)
            begin
                if (en)
                    item_reg[k] <= item_reg[k-1];
            end
        end
        else
        begin : g_sat
            always_ff @(posedge clk)
            begin
                if (en)
                    item_reg[k] <= sat_item;
            end
        end
    end

    assign out_valid = valid_reg[LAT-1];
    assign out_item = item_reg[LAT-1];

endmodule

// ===== hw/rtl/v2rn_divide.sv =====
`timescale 1ns / 1ps

module v2rn_divide (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  v2rn_pkg::item_t in_item,
    output logic            out_valid,
    output v2rn_pkg::item_t out_item
);
    import v2rn_pkg::*;

    localparam int QB = 32;
    localparam int DIV0 = 2;
    localparam int SAT_IDX = DIV0 + QB + 1;
    localparam int LAT = SAT_IDX + 2;

    logic [LAT-1:0]     valid_reg;
    item_t              item_reg [0:LAT-1];
    logic [31:0]        m_reg [0:1];
    logic [30:0]        num_reg;
    logic [62:0]        prod_reg [0:1];
    logic [33:0]        rem_reg [0:1][0:QB];
    logic [31:0]        lo_reg [0:1][0:QB];
    logic [31:0]        q_reg [0:1][0:QB];
    logic               ovf_reg [0:1][0:QB];
    logic [31:0]        dres_reg [0:1];
    logic signed [31:0] comp [0:1];
    logic [62:0]        nsum [0:1];
    item_t              sel;
    logic signed [31:0] sx;
    logic signed [31:0] sy;

    assign comp[0] = in_item.x;
    assign comp[1] = in_item.y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[LAT-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg[0] <= in_item;
            num_reg <= (in_item.action == ACT_NORMALIZE) ? NORM_NUM : in_item.len_arg;
        end
    end

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        // rounding term is half the length
        assign nsum[l] = prod_reg[l] + {31'b0, item_reg[1].len[LEN_W-1:1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg[l]      <= comp[l][31] ? -comp[l] : comp[l];
                prod_reg[l]   <= {31'b0, m_reg[l]} * {32'b0, num_reg};
                rem_reg[l][0] <= {3'b0, nsum[l][62:32]};
                lo_reg[l][0]  <= nsum[l][31:0];
                q_reg[l][0]   <= '0;
                ovf_reg[l][0] <= {2'b0, nsum[l][62:32]} >= item_reg[1].len;
            end
        end

        // restoring division, one quotient bit per stage
        for (genvar j = 0; j < QB; j++)
        begin : g_bit
            logic [33:0] t;
            logic        ge;
            assign t = {rem_reg[l][j][32:0], lo_reg[l][j][31]};
            assign ge = t >= {1'b0, item_reg[DIV0+j].len};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[l][j+1] <= ge ? t - {1'b0, item_reg[DIV0+j].len} : t;
                    lo_reg[l][j+1]  <= {lo_reg[l][j][30:0], 1'b0};
                    q_reg[l][j+1]   <= {q_reg[l][j][30:0], ge};
                    ovf_reg[l][j+1] <= ovf_reg[l][j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dres_reg[0] <= sat_apply(item_reg[SAT_IDX-1].x[31],
                ovf_reg[0][QB] ? DSC_W'(34'h1_0000_0000) : {2'b0, q_reg[0][QB]});
            dres_reg[1] <= sat_apply(item_reg[SAT_IDX-1].y[31],
                ovf_reg[1][QB] ? DSC_W'(34'h1_0000_0000) : {2'b0, q_reg[1][QB]});
        end
    end

    // final result choice per action
    always_comb
    begin
        sel = item_reg[SAT_IDX];
        sx = sel.x;
        sy = sel.y;
        unique case (sel.action)
            ACT_ROTATE, ACT_POLAR, ACT_SET_ORI:
            begin
            end
            ACT_ROT_P90:
            begin
                sel.res_x = (sy == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -sy;
                sel.res_y = sx;
            end
            ACT_ROT_M90:
            begin
                sel.res_x = sy;
                sel.res_y = (sx == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -sx;
            end
            ACT_NORMALIZE:
            begin
                sel.res_x = (sel.len == '0) ? 32'sh0 : dres_reg[0];
                sel.res_y = (sel.len == '0) ? 32'sh0 : dres_reg[1];
            end
            ACT_CLAMP:
            begin
                if (sel.len > {2'b0, sel.len_arg} && sel.len != '0)
                begin
                    sel.res_x = dres_reg[0];
                    sel.res_y = dres_reg[1];
                end
                else
                begin
                    sel.res_x = sx;
                    sel.res_y = sy;
                end
            end
            ACT_SET_LEN:
            begin
                if (sel.len != '0)
                begin
                    sel.res_x = dres_reg[0];
                    sel.res_y = dres_reg[1];
                end
                else
                begin
                    sel.res_x = sx;
                    sel.res_y = sy;
                end
            end
        endcase
    end

    for (genvar k = 1; k < LAT; k++)
    begin : g_item
        if (k != LAT - 1)
        begin : g_copy
            always_ff @(posedge clk)
            begin
                if (en)
                    item_reg[k] <= item_reg[k-1];
            end
        end
        else
        begin : g_last
            always_ff @(posedge clk)
            begin
                if (en)
                    item_reg[k] <= sel;
            end
        end
    end

    assign out_valid = valid_reg[LAT-1];
    assign out_item = item_reg[LAT-1];

endmodule

// ===== hw/rtl/vector2_rotate_normalize_unit.sv =====
`timescale 1ns / 1ps

// channel   handshake             payload
// in        in_valid / in_stall   action, in_x, in_y, angle_arg, length_arg
// out       out_valid / out_stall res_x, res_y, input_length, input_orientation
//
// one request per cycle while in_stall is low; the path runs through
// the vectoring cordic, the rotation cordic and the 32-step restoring divider
// async active-low reset clears valid bits only, no clearing pass
// in_stall comes from a register: it rises only while the output skid stage is full
// a stall freezes every stage in place, nothing dropped or repeated

module vector2_rotate_normalize_unit #(
    parameter int ROTATION_STAGES = v2rn_pkg::ROTATION_STAGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic signed [31:0] in_x,
    input  logic signed [31:0] in_y,
    input  logic [15:0] angle_arg,
    input  logic [30:0] length_arg,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] res_x,
    output logic signed [31:0] res_y,
    output logic [30:0] input_length,
    output logic [15:0] input_orientation
);
    import v2rn_pkg::*;

    // whole pipeline advances unless the skid stage holds a result
    logic  en;
    item_t in_item;
    logic  vec_valid;
    item_t vec_item;
    logic  rot_valid;
    item_t rot_item;
    logic  pipe_valid;
    item_t pipe_item;
    logic  out_valid_reg;
    logic  skid_valid_reg;
    item_t out_item_reg;
    item_t skid_item_reg;
    logic  out_free;

    assign en = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    always_comb
    begin
        in_item = '0;
        in_item.action  = action;
        in_item.x       = in_x;
        in_item.y       = in_y;
        in_item.angle   = angle_arg;
        in_item.len_arg = length_arg;
    end

    // length and orientation of the input vector
    v2rn_vector #(
        .STAGES (ROTATION_STAGES)
    ) u_vector (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .out_valid (vec_valid),
        .out_item  (vec_item)
    );

    // rotate, polar and set-orientation results
    v2rn_rotate #(
        .STAGES (ROTATION_STAGES)
    ) u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vec_valid),
        .in_item   (vec_item),
        .out_valid (rot_valid),
        .out_item  (rot_item)
    );

    // length scaling by division, quarter turns, final choice
    v2rn_divide u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rot_valid),
        .in_item   (rot_item),
        .out_valid (pipe_valid),
        .out_item  (pipe_item)
    );

    // output register plus skid entry
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= pipe_valid;
        end
        else if (pipe_valid && en)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_item_reg <= skid_item_reg;
            else
                out_item_reg <= pipe_item;
        end
        else if (pipe_valid && en)
            skid_item_reg <= pipe_item;
    end

    assign out_valid         = out_valid_reg;
    assign res_x             = out_item_reg.res_x;
    assign res_y             = out_item_reg.res_y;
    assign input_length      = out_item_reg.len_sat;
    assign input_orientation = out_item_reg.ori;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

// testbench for vector2_rotate_normalize_unit
// directed table first, then random requests; every accepted request gets an expected
// result, typed in for the obvious directed rows, else from a bit-exact cordic / divider
// predictor, queued for the output checker, which compares field by field in order of arrival

module testbench;

    import v2rn_pkg::*;

    // one request as driven on the input channel
    typedef struct {
        logic [2:0]         act;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [15:0]        ang;
        logic [30:0]        len;
    } vec_req_t;

    // one result as seen on the output channel
    typedef struct {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic [30:0]        mag;
        logic [15:0]        ori;
    } vec_res_t;

    // directed row: request, plus a typed-in result where it is obvious
    typedef struct {
        vec_req_t req;
        bit       known;
        vec_res_t res;
    } dir_row_t;

    localparam int IDLE_PCT    = 11;
    localparam int RAND_ITEMS  = 700;
    localparam int DRAIN_WAIT  = 2 * ROTATION_STAGES_DEF + 46 + 40;
    localparam int NDIR        = 22;
    localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SMIN = 32'sh8000_0000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  action;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic [15:0] angle_arg;
    logic [30:0] length_arg;
    logic        out_valid;
    logic        out_stall;
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic [30:0] input_length;
    logic [15:0] input_orientation;

    vec_res_t    pending_res_q[$];
    int          err_cnt;
    int          sent_cnt;
    int          recv_cnt;
    int          act_cnt[8];
    bit          no_idle;

    vector2_rotate_normalize_unit u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .action            (action),
        .in_x              (in_x),
        .in_y              (in_y),
        .angle_arg         (angle_arg),
        .length_arg        (length_arg),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .res_x             (res_x),
        .res_y             (res_y),
        .input_length      (input_length),
        .input_orientation (input_orientation)
    );

    // clock, 20 ns period
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard limit on the whole run
    initial
    begin
        #5_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    // ---------------- predictor ----------------

    function automatic longint sat_s32(input longint v);
        if (v > 64'sh7FFF_FFFF)
            return 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000)
            return -64'sh8000_0000;
        return v;
    endfunction

    // strip cordic gain and guard bits, round half up on the magnitude
    function automatic longint unsigned strip_gain(input longint unsigned m);
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned p;
        hi = m >> 32;
        lo = m & 64'hFFFF_FFFF;
        p  = hi * INV_GAIN + ((lo * INV_GAIN) >> 32);
        return (p + (64'd1 << (GUARD_BITS - 1))) >> GUARD_BITS;
    endfunction

    function automatic longint gain_out(input longint v);
        longint unsigned m;
        longint r;
        m = (v < 0) ? longint'(-v) : longint'(v);
        r = longint'(strip_gain(m));
        return sat_s32((v < 0) ? -r : r);
    endfunction

    // round(|c| * num / den) half away from zero, sign of c, saturated
    function automatic longint ratio_scale(input longint c, input longint unsigned num,
                                           input longint unsigned den);
        longint unsigned m;
        longint q;
        m = (c < 0) ? longint'(-c) : longint'(c);
        q = longint'((m * num + den / 2) / den);
        return sat_s32((c < 0) ? -q : q);
    endfunction

    // vectoring cordic: length (unsaturated) and orientation
    function automatic void vec_polar(input longint x0, input longint y0,
                                      output longint unsigned mag, output logic [15:0] ori);
        longint x;
        longint y;
        longint bx;
        longint by;
        longint dx;
        longint dy;
        logic [31:0] z;
        logic [31:0] zr;
        x = x0;
        y = y0;
        z = 32'd0;
        if (x == 0 && y == 0)
        begin
            mag = 0;
            ori = 16'd0;
            return;
        end
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        bx = x * 65536;
        by = y * 65536;
        for (int i = 0; i < ROTATION_STAGES_DEF; i++)
        begin
            dx = by >>> (i & 31);
            dy = bx >>> (i & 31);
            if (by >= 0)
            begin
                bx = bx + dx;
                by = by - dy;
                z  = z + ATAN_TURNS[i & 31];
            end
            else
            begin
                bx = bx - dx;
                by = by + dy;
                z  = z - ATAN_TURNS[i & 31];
            end
        end
        mag = strip_gain(longint'(bx));
        zr  = z + 32'h8000;
        ori = zr[31:16];
    endfunction

    // rotation cordic by a binary angle
    function automatic void vec_turn(input longint x0, input longint y0,
                                     input logic [15:0] a16,
                                     output longint ox, output longint oy);
        longint x;
        longint y;
        longint bx;
        longint by;
        longint dx;
        longint dy;
        longint r;
        logic [31:0] z;
        logic [31:0] t;
        x = x0;
        y = y0;
        z = {a16, 16'd0};
        t = z + 32'h4000_0000;
        if (t[31])
        begin
            x = -x;
            y = -y;
            z = z + 32'h8000_0000;
        end
        r  = longint'($signed(z));
        bx = x * 65536;
        by = y * 65536;
        for (int i = 0; i < ROTATION_STAGES_DEF; i++)
        begin
            dx = by >>> (i & 31);
            dy = bx >>> (i & 31);
            if (r >= 0)
            begin
                bx = bx - dx;
                by = by + dy;
                r  = r - longint'(ATAN_TURNS[i & 31]);
            end
            else
            begin
                bx = bx + dx;
                by = by - dy;
                r  = r + longint'(ATAN_TURNS[i & 31]);
            end
        end
        ox = gain_out(bx);
        oy = gain_out(by);
    endfunction

    function automatic vec_res_t predict_vec(input vec_req_t q);
        vec_res_t o;
        longint x;
        longint y;
        longint rx;
        longint ry;
        longint unsigned mag;
        longint unsigned mag_sat;
        longint unsigned larg;
        logic [15:0] ori;
        x    = longint'(q.vx);
        y    = longint'(q.vy);
        larg = longint'(q.len);
        rx   = x;
        ry   = y;
        vec_polar(x, y, mag, ori);
        mag_sat = (mag > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : mag;
        case (q.act)
            ACT_ROTATE:    vec_turn(x, y, q.ang, rx, ry);
            ACT_ROT_P90:
            begin
                rx = sat_s32(-y);
                ry = x;
            end
            ACT_ROT_M90:
            begin
                rx = y;
                ry = sat_s32(-x);
            end
            ACT_POLAR:     vec_turn(longint'(larg), 0, q.ang, rx, ry);
            ACT_SET_ORI:   vec_turn(longint'(mag_sat), 0, q.ang, rx, ry);
            ACT_NORMALIZE:
            begin
                if (mag == 0)
                begin
                    rx = 0;
                    ry = 0;
                end
                else
                begin
                    rx = ratio_scale(x, 64'd1 << FRACTION_BITS, mag);
                    ry = ratio_scale(y, 64'd1 << FRACTION_BITS, mag);
                end
            end
            ACT_CLAMP:
            begin
                if (mag > larg && mag > 0)
                begin
                    rx = ratio_scale(x, larg, mag);
                    ry = ratio_scale(y, larg, mag);
                end
            end
            default:
            begin
                if (mag > 0)
                begin
                    rx = ratio_scale(x, larg, mag);
                    ry = ratio_scale(y, larg, mag);
                end
            end
        endcase
        o.rx  = rx[31:0];
        o.ry  = ry[31:0];
        o.mag = mag_sat[30:0];
        o.ori = ori;
        return o;
    endfunction

    // ---------------- input side ----------------

    // idle a random number of cycles, present the request, wait for acceptance.
    // in_stall is a register, so sampling it at the falling edge is race free
    task automatic send_req(input vec_req_t q, input vec_res_t res);
        bit st;
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= q.act;
        in_x       <= q.vx;
        in_y       <= q.vy;
        angle_arg  <= q.ang;
        length_arg <= q.len;
        forever
        begin
            @(negedge clk);
            st = in_stall;
            @(posedge clk);
            if (!st)
                break;
        end
        pending_res_q.push_back(res);
        sent_cnt++;
        act_cnt[q.act]++;
    endtask

    function automatic logic signed [31:0] rand_comp();
        logic signed [31:0] v;
        case ($urandom_range(0, 7))
            0:       v = SMAX;
            1:       v = SMIN;
            2:       v = 32'sd0;
            3:       v = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            4:       v = $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [30:0] rand_len();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 4))
            0:       return LEN_MAX;
            1:       return 31'd0;
            2:       return 31'(r[22:0]);
            default: return r[30:0];
        endcase
    endfunction

    // ---------------- output side ----------------

    // random stall on the result channel
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // a result is taken at the next rising edge when valid and not stalled;
    // out_valid and the payload come from registers, so check at the falling edge
    always @(negedge clk)
    begin
        vec_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            recv_cnt++;
            if (pending_res_q.size() == 0)
            begin
                $error("result with nothing expected: x=%0d y=%0d", res_x, res_y);
                err_cnt++;
            end
            else
            begin
                want = pending_res_q.pop_front();
                if (res_x !== want.rx)
                begin
                    $error("res_x expected %0d got %0d", want.rx, res_x);
                    err_cnt++;
                end
                if (res_y !== want.ry)
                begin
                    $error("res_y expected %0d got %0d", want.ry, res_y);
                    err_cnt++;
                end
                if (input_length !== want.mag)
                begin
                    $error("input_length expected %0d got %0d", want.mag, input_length);
                    err_cnt++;
                end
                if (input_orientation !== want.ori)
                begin
                    $error("input_orientation expected %0d got %0d",
                           want.ori, input_orientation);
                    err_cnt++;
                end
            end
        end
    end

    // ---------------- stimulus ----------------

    dir_row_t dir_tab [NDIR];
    vec_res_t zero_res;

    initial
    begin
        vec_req_t rq;
        vec_res_t rs;
        int       wait_cnt;

        zero_res = '{32'sd0, 32'sd0, 31'd0, 16'd0};
        // zero vector: length and orientation 0, result stays at the origin
        dir_tab[0]  = '{'{ACT_NORMALIZE, 32'sd0, 32'sd0, 16'h0000, 31'd0}, 1'b1, zero_res};
        dir_tab[1]  = '{'{ACT_CLAMP, 32'sd0, 32'sd0, 16'h0000, 31'd100}, 1'b1, zero_res};
        dir_tab[2]  = '{'{ACT_SET_LEN, 32'sd0, 32'sd0, 16'h0000, LEN_MAX}, 1'b1, zero_res};
        dir_tab[3]  = '{'{ACT_ROTATE, 32'sd0, 32'sd0, 16'h1234, 31'd0}, 1'b1, zero_res};
        // quarter turns of the most negative value saturate
        dir_tab[4]  = '{'{ACT_ROT_P90, 32'sd0, SMIN, 16'h0000, 31'd0}, 1'b0, zero_res};
        dir_tab[5]  = '{'{ACT_ROT_M90, SMIN, 32'sd0, 16'hFFFF, 31'd0}, 1'b0, zero_res};
        dir_tab[6]  = '{'{ACT_ROT_P90, SMAX, SMIN, 16'h0000, 31'd0}, 1'b0, zero_res};
        // rotate at the quadrant boundaries and the angle extremes
        dir_tab[7]  = '{'{ACT_ROTATE, SMAX, SMAX, 16'h0000, 31'd0}, 1'b0, zero_res};
        dir_tab[8]  = '{'{ACT_ROTATE, SMAX, SMAX, 16'hFFFF, 31'd0}, 1'b0, zero_res};
        dir_tab[9]  = '{'{ACT_ROTATE, SMIN, SMIN, 16'h4000, 31'd0}, 1'b0, zero_res};
        dir_tab[10] = '{'{ACT_ROTATE, 32'sh0001_0000, 32'sd0, 16'h8000, 31'd0}, 1'b0, zero_res};
        dir_tab[11] = '{'{ACT_ROTATE, -32'sd1, -32'sd1, 16'hC000, 31'd0}, 1'b0, zero_res};
        // polar with extreme lengths
        dir_tab[12] = '{'{ACT_POLAR, 32'sd5, 32'sd7, 16'h2000, LEN_MAX}, 1'b0, zero_res};
        dir_tab[13] = '{'{ACT_POLAR, SMIN, SMAX, 16'h3FFF, 31'd0}, 1'b0, zero_res};
        // set orientation uses the saturated length
        dir_tab[14] = '{'{ACT_SET_ORI, SMAX, SMIN, 16'h1234, 31'd0}, 1'b0, zero_res};
        dir_tab[15] = '{'{ACT_SET_ORI, SMIN, SMIN, 16'hFFFF, 31'd0}, 1'b0, zero_res};
        // normalize, clamp on both sides of the limit, set length
        dir_tab[16] = '{'{ACT_NORMALIZE, 32'sd1, 32'sd0, 16'h0000, 31'd0}, 1'b0, zero_res};
        dir_tab[17] = '{'{ACT_NORMALIZE, SMIN, SMIN, 16'h0000, 31'd0}, 1'b0, zero_res};
        dir_tab[18] = '{'{ACT_CLAMP, 32'sh0003_0000, 32'sh0004_0000, 16'h0000, LEN_MAX},
                        1'b0, zero_res};
        dir_tab[19] = '{'{ACT_CLAMP, SMAX, SMAX, 16'h0000, 31'h0001_0000}, 1'b0, zero_res};
        dir_tab[20] = '{'{ACT_SET_LEN, 32'sd1, 32'sd1, 16'h0000, LEN_MAX}, 1'b0, zero_res};
        dir_tab[21] = '{'{ACT_SET_LEN, SMIN, 32'sd3, 16'h0000, 31'd0}, 1'b0, zero_res};

        err_cnt    = 0;
        sent_cnt   = 0;
        recv_cnt   = 0;
        no_idle    = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        action     = ACT_ROTATE;
        in_x       = '0;
        in_y       = '0;
        angle_arg  = '0;
        length_arg = '0;
        foreach (act_cnt[i])
            act_cnt[i] = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < NDIR; i++)
        begin
            rs = dir_tab[i].known ? dir_tab[i].res : predict_vec(dir_tab[i].req);
            send_req(dir_tab[i].req, rs);
        end

        // random part, with a stretch at full rate on both sides in the middle
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            no_idle  = (n >= 250 && n < 400);
            rq.act   = 3'($urandom_range(0, 7));
            rq.vx    = rand_comp();
            rq.vy    = rand_comp();
            rq.ang   = 16'($urandom);
            rq.len   = rand_len();
            send_req(rq, predict_vec(rq));
        end
        in_valid <= 1'b0;
        no_idle = 1'b0;

        // drain
        wait_cnt = 0;
        while (pending_res_q.size() != 0 && wait_cnt < 20000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("run: %0d requests sent, %0d results checked, %0d mismatches",
                 sent_cnt, recv_cnt, err_cnt);
        $display("per action: %0d %0d %0d %0d %0d %0d %0d %0d", act_cnt[0], act_cnt[1],
                 act_cnt[2], act_cnt[3], act_cnt[4], act_cnt[5], act_cnt[6], act_cnt[7]);
        if (pending_res_q.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_res_q.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/v2rn_pkg.sv
hw/rtl/v2rn_descale.sv
hw/rtl/v2rn_vector.sv
hw/rtl/v2rn_rotate.sv
hw/rtl/v2rn_divide.sv
hw/rtl/vector2_rotate_normalize_unit.sv
tb/testbench.sv
